// ===== design/char_literal_parser_defines.svh =====
// Assertion macros for the character literal parser top level.
`ifndef CHAR_LITERAL_PARSER_DEFINES_SVH
`define CHAR_LITERAL_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("char_literal_parser assertion failed");

// Next-cycle implication, checked out of reset.
`define CLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("char_literal_parser assertion failed");

`endif

// ===== design/clp_pkg.sv =====
// Types, character constants and decode functions for the character literal parser.
package clp_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [3:0] COUNT_MAX = 4'd15;
    localparam logic [3:0] PREFIX_LAST = 4'd5;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_PREFIX      = 4'd1,
        PH_BODY        = 4'd2,
        PH_PLAIN_CLOSE = 4'd3,
        PH_ESC_SYM     = 4'd4,
        PH_ESC_SECOND  = 4'd5,
        PH_HEX_CLOSE   = 4'd6
    } phase_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] char_byte;
    } in_beat_t;

    typedef struct packed {
        logic       status;
        logic [7:0] char_value;
        logic [3:0] consumed;
    } out_beat_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] held_symbol;
        logic [3:0] byte_count;
    } clp_state_t;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CH_C;
            4'd1:    c = CH_H;
            4'd2:    c = CH_A;
            4'd3:    c = CH_R;
            4'd4:    c = CH_HASH;
            4'd5:    c = CH_QUOTE;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c - 8'h30;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = c - 8'h57;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c - 8'h37;
        end else begin
            v = 8'h00;
        end
        return v[3:0];
    endfunction

endpackage

// ===== design/clp_step.sv =====
// Per-byte next-state and result decode of the character literal parser.
module clp_step (
    input  clp_pkg::in_beat_t   beat,
    input  clp_pkg::clp_state_t cur,
    output clp_pkg::clp_state_t nxt,
    output logic                has_result,
    output clp_pkg::out_beat_t  result
);
    import clp_pkg::*;

    logic [3:0] count_inc;
    logic [3:0] prefix_idx;
    logic [7:0] sym_upper;
    logic       emit;
    logic       err;
    logic [7:0] val;

    always_comb begin
        count_inc  = (cur.byte_count < COUNT_MAX) ? cur.byte_count + 4'd1 : cur.byte_count;
        prefix_idx = count_inc - 4'd1;
        sym_upper  = ((cur.held_symbol >= 8'h61) && (cur.held_symbol <= 8'h7A))
                   ? cur.held_symbol - 8'h20 : cur.held_symbol;
        nxt  = cur;
        emit = 1'b0;
        err  = 1'b0;
        val  = 8'h00;
        if (beat.start_req) begin
            nxt.byte_count  = 4'd1;
            nxt.held_symbol = 8'h00;
            if (beat.char_byte == CH_QUOTE) begin
                nxt.phase = PH_BODY;
            end else if (beat.char_byte == CH_C) begin
                nxt.phase = PH_PREFIX;
            end else begin
                emit = 1'b1;
                err  = 1'b1;
            end
        end else if (cur.phase != PH_IDLE) begin
            nxt.byte_count = count_inc;
            if (beat.char_byte == CH_NUL) begin
                emit = 1'b1;
                err  = 1'b1;
            end else begin
                case (cur.phase)
                    PH_PREFIX: begin
                        if (prefix_idx > PREFIX_LAST
                            || beat.char_byte != prefix_char(prefix_idx)) begin
                            emit = 1'b1;
                            err  = 1'b1;
                        end else if (prefix_idx == PREFIX_LAST) begin
                            nxt.phase = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (beat.char_byte == CH_QUOTE) begin
                            emit = 1'b1;
                        end else if (beat.char_byte == CH_DOLLAR) begin
                            nxt.phase = PH_ESC_SYM;
                        end else begin
                            nxt.held_symbol = beat.char_byte;
                            nxt.phase       = PH_PLAIN_CLOSE;
                        end
                    end
                    PH_PLAIN_CLOSE, PH_HEX_CLOSE: begin
                        emit = 1'b1;
                        err  = (beat.char_byte != CH_QUOTE);
                        val  = cur.held_symbol;
                    end
                    PH_ESC_SYM: begin
                        nxt.held_symbol = beat.char_byte;
                        nxt.phase       = PH_ESC_SECOND;
                    end
                    PH_ESC_SECOND: begin
                        if (beat.char_byte == CH_QUOTE) begin
                            emit = 1'b1;
                            case (sym_upper)
                                CH_DOLLAR: val = CH_DOLLAR;
                                CH_QUOTE:  val = CH_QUOTE;
                                CH_L:      val = CH_LF;
                                CH_N:      val = CH_LF;
                                CH_P:      val = CH_FF;
                                CH_R:      val = CH_CR;
                                CH_T:      val = CH_TAB;
                                default:   err = 1'b1;
                            endcase
                        end else if (is_hex(cur.held_symbol) && is_hex(beat.char_byte)) begin
                            nxt.held_symbol = {hex_val(cur.held_symbol), hex_val(beat.char_byte)};
                            nxt.phase       = PH_HEX_CLOSE;
                        end else begin
                            emit = 1'b1;
                            err  = 1'b1;
                        end
                    end
                    default: begin
                        emit = 1'b1;
                        err  = 1'b1;
                    end
                endcase
            end
        end
        if (emit) begin
            nxt.phase = PH_IDLE;
        end
        has_result        = emit;
        result.status     = err;
        result.char_value = err ? 8'h00 : val;
        result.consumed   = err ? 4'd0 : nxt.byte_count;
    end

endmodule

// ===== design/char_literal_parser.sv =====
// Top level of the character literal parser: input register, parser state and result register.
// Takes one byte of literal text per beat and emits one result beat (status, decoded value,
// bytes consumed) when a literal closes or a byte breaks it. Each byte is held in the input
// register and decoded against the parser state combinationally, so a new byte is accepted
// every cycle; a stalled result only holds the input side when the waiting byte would
// itself produce a result. Bytes that arrive while no literal is open are dropped without a
// result, and a start_req beat drops any open literal without a result.
`include "char_literal_parser_defines.svh"

module char_literal_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  clp_pkg::in_beat_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output clp_pkg::out_beat_t m_payload
);
    import clp_pkg::*;

    logic       in_valid_reg;
    in_beat_t   in_beat_reg;
    clp_state_t state_reg;
    clp_state_t state_next;
    logic       out_valid_reg;
    out_beat_t  out_beat_reg;
    logic       has_result;
    out_beat_t  result;
    logic       advance;
    logic       out_ok;
    logic       out_err;
    logic [3:0] out_count;
    logic       blocked;

    clp_step u_step (
        .beat       (in_beat_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .result     (result)
    );

    assign advance = in_valid_reg && (!has_result || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_payload = out_beat_reg;

    assign out_ok    = m_valid && !m_payload.status;
    assign out_err   = m_valid && m_payload.status;
    assign out_count = m_payload.consumed;
    assign blocked   = in_valid_reg && !advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= PH_IDLE;
            state_reg.held_symbol <= 8'h00;
            state_reg.byte_count  <= 4'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_beat_reg  <= s_payload;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && has_result) begin
                out_valid_reg <= 1'b1;
                out_beat_reg  <= result;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `CLP_ASSERT_NOW(a_ok_count_range, out_ok, (out_count >= 4'd2) && (out_count <= 4'd10))
    `CLP_ASSERT_NOW(a_err_zeroed, out_err, (m_payload.char_value == 8'h00) && (out_count == 4'd0))
    `CLP_ASSERT_NEXT(a_idle_after_result, advance && has_result, state_reg.phase == PH_IDLE)
    `CLP_ASSERT_NOW(a_count_when_busy, state_reg.phase != PH_IDLE, state_reg.byte_count != 4'd0)
    `CLP_ASSERT_NEXT(a_hold_blocked_byte, blocked, in_valid_reg && $stable(in_beat_reg))

endmodule
